@@ hdl/psfd_pkg.sv @@
// Shared constants for the particulate sensor frame decoder.
// Used by the decoder top level and by its port checker; no dependencies.
package psfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  localparam logic [15:0] FRAME_LEN_WORD = 16'd28;

  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd3;
  localparam logic [POS_W-1:0] POS_WORD_BASE = 5'd10;
  localparam logic [POS_W-1:0] POS_WORD_LAST = 5'd27;
  localparam logic [POS_W-1:0] POS_SUM_HI    = 5'd30;
  localparam logic [POS_W-1:0] POS_SUM_LO    = 5'd31;

  localparam int WORD_COUNT = 9;
  localparam int WORD_IDX_W = 4;
  localparam int DATA_W     = 16 * WORD_COUNT;

  // Sync phase codes.
  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_HDR     = 2'd1;
  localparam logic [1:0] PH_COLLECT = 2'd2;

  // Frame status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEN_ERR = 2'd1;
  localparam logic [1:0] ST_SUM_ERR = 2'd2;

endpackage

@@ hdl/particle_sensor_frame_decoder.sv @@
// Particulate sensor frame decoder: header hunt, 32-byte frame capture and
// checksum, result formatting. Depends on psfd_pkg.
//
// The block takes one sensor byte per clock on the slave stream while s_tready
// is high. It hunts for the header 0x42 0x4D (a repeated 0x42 keeps it waiting
// for 0x4D), then collects the remaining 30 frame bytes while summing bytes 0
// to 29. The 32nd byte of a frame produces one result transaction on the master
// stream on the next clock: m_tuser carries the status (0 ok, 1 length word not
// 28, 2 checksum mismatch) and m_tdata the three mass words and six size bins,
// all zero on an error. The only stall is s_tready low while a finished result
// is held in the output register and m_tready is low.
module particle_sensor_frame_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,  // data_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // mass_pm1, mass_pm2_5, mass_pm10, bin_03_to_05, bin_05_to_10,
  // bin_10_to_25, bin_25_to_50, bin_50_to_100, bin_100_up (16 bits each)
  output logic [psfd_pkg::DATA_W-1:0]  m_tdata,
  output logic [1:0]                   m_tuser   // frame_status
);
  import psfd_pkg::*;

  logic [1:0]        sync_phase, sync_phase_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [15:0]       running_sum, running_sum_next;
  logic [15:0]       length_word;
  logic [15:0]       words [WORD_COUNT];
  logic [7:0]        received_sum_high;

  logic              accept;
  logic              collecting;
  logic              frame_done;
  logic [POS_W-1:0]  word_off;
  logic [WORD_IDX_W-1:0] word_idx;
  logic              in_words;
  logic [15:0]       rx_sum;
  logic [1:0]        status;
  logic [DATA_W-1:0] data_ok;

  function automatic logic [15:0] floor_sub(input logic [15:0] a, input logic [15:0] b);
    floor_sub = (a > b) ? (a - b) : 16'd0;
  endfunction

  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign collecting = (sync_phase == PH_COLLECT);
  assign frame_done = accept && collecting && (byte_position == POS_SUM_LO);

  assign word_off = byte_position - POS_WORD_BASE;
  assign word_idx = word_off[WORD_IDX_W:1];
  assign in_words = (byte_position >= POS_WORD_BASE) && (byte_position <= POS_WORD_LAST);

  always_comb begin
    sync_phase_next    = sync_phase;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    case (sync_phase)
      PH_HDR: begin
        if (s_tdata == HDR_SECOND) begin
          sync_phase_next    = PH_COLLECT;
          byte_position_next = POS_LEN_HI;
          running_sum_next   = 16'(HDR_FIRST) + 16'(HDR_SECOND);
        end else if (s_tdata != HDR_FIRST) begin
          sync_phase_next = PH_HUNT;
        end
      end
      PH_COLLECT: begin
        if (byte_position < POS_SUM_HI) begin
          running_sum_next = running_sum + 16'(s_tdata);
        end
        if (byte_position == POS_SUM_LO) begin
          sync_phase_next    = PH_HUNT;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 1'b1;
        end
      end
      default: begin
        sync_phase_next    = (s_tdata == HDR_FIRST) ? PH_HDR : PH_HUNT;
        byte_position_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_phase    <= PH_HUNT;
      byte_position <= '0;
      running_sum   <= '0;
    end else if (accept) begin
      sync_phase    <= sync_phase_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  // Frame field capture; big-endian words, high byte at the even position.
  always_ff @(posedge clk) begin
    if (accept && collecting) begin
      if (byte_position == POS_LEN_HI) length_word[15:8] <= s_tdata;
      if (byte_position == POS_LEN_LO) length_word[7:0]  <= s_tdata;
      if (in_words) begin
        if (!byte_position[0]) words[word_idx][15:8] <= s_tdata;
        else                   words[word_idx][7:0]  <= s_tdata;
      end
      if (byte_position == POS_SUM_HI) received_sum_high <= s_tdata;
    end
  end

  // The final byte is the low half of the received checksum.
  assign rx_sum = {received_sum_high, s_tdata};

  always_comb begin
    if (length_word != FRAME_LEN_WORD)  status = ST_LEN_ERR;
    else if (running_sum != rx_sum)     status = ST_SUM_ERR;
    else                                status = ST_OK;
  end

  assign data_ok = {words[8],
                    floor_sub(words[7], words[8]),
                    floor_sub(words[6], words[7]),
                    floor_sub(words[5], words[6]),
                    floor_sub(words[4], words[5]),
                    floor_sub(words[3], words[4]),
                    words[2], words[1], words[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (frame_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      m_tuser <= status;
      m_tdata <= (status == ST_OK) ? data_ok : '0;
    end
  end

endmodule

@@ hdl/psfd_port_check.sv @@
// Port-level checker for the particulate sensor frame decoder, bound to the
// top level. Depends on psfd_pkg.
module psfd_port_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tready,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [psfd_pkg::DATA_W-1:0] m_tdata,
  input logic [1:0]                  m_tuser
);
  import psfd_pkg::*;

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result transaction changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_LEN_ERR || m_tuser == ST_SUM_ERR))
    else $error("undefined frame status");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("error result carries nonzero data");

  // The input side only waits on a pending, stalled result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled with free output register");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind particle_sensor_frame_decoder psfd_port_check u_psfd_port_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
